/* hdl/tfag_pkg.sv */
// ----------------------------------------------------------------------------
// tfag_pkg
// Shared types, codes and constants of the channel-major tile fetch
// address generator.
// ----------------------------------------------------------------------------
package tfag_pkg;

    // Block constants
    localparam int VECTOR_WIDTH = 8;
    localparam int PORT_COUNT   = 4;
    localparam int BUFFER_ROWS  = 4096;

    // Field widths
    localparam int TILE_IDX_W  = 12;
    localparam int ADDR_W      = 32;
    localparam int ROW_W       = 12;
    localparam int PORT_W      = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

    // Configuration register widths
    localparam int CFG_CH_W    = 13;
    localparam int CFG_DIM_W   = 9;
    localparam int CFG_FRAME_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_CHANNELS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_OUT_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_OUT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_IN_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_IN_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIDE      = 3'd5;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Datapath widths
    localparam int MUL_W      = 32;
    localparam int GRP_W      = 13;   // holds the group count itself (up to 4096)
    localparam int GRP_CNT_W  = 12;
    localparam int DIM_CNT_W  = 8;
    localparam int STRIDE_W   = 9;
    localparam int ROW_ACC_W  = 30;

    localparam logic [GRP_W-1:0]     GROUPS_MAX = 13'd4096;
    localparam logic [CFG_DIM_W-1:0] DIM_MAX    = 9'd256;

    typedef struct packed {
        logic [CFG_CH_W-1:0]    tile_channels;
        logic [CFG_DIM_W-1:0]   tile_out_height;
        logic [CFG_DIM_W-1:0]   tile_out_width;
        logic [CFG_DIM_W-1:0]   tile_in_height;
        logic [CFG_DIM_W-1:0]   tile_in_width;
        logic [CFG_FRAME_W-1:0] frame_side;
    } cfg_t;

    // Micro-operations of the shared multiplier sequence
    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_FF,
        UOP_CH,
        UOP_Y,
        UOP_CF,
        UOP_YF,
        UOP_X,
        UOP_GI,
        UOP_RH,
        UOP_RS,
        UOP_FIN
    } uop_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FF,
        ST_CH,
        ST_Y,
        ST_CF,
        ST_YF,
        ST_X,
        ST_GI,
        ST_RH,
        ST_RS,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic start_load;
        uop_t uop;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic out_busy;
    } status_t;

endpackage

/* hdl/tfag_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tfag_cfg_regs
// Write-only configuration register file, masked to each register's width.
// ----------------------------------------------------------------------------
module tfag_cfg_regs
    import tfag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TILE_CHANNELS:   cfg_next.tile_channels   = cfg_data[CFG_CH_W-1:0];
                CFG_TILE_OUT_HEIGHT: cfg_next.tile_out_height = cfg_data[CFG_DIM_W-1:0];
                CFG_TILE_OUT_WIDTH:  cfg_next.tile_out_width  = cfg_data[CFG_DIM_W-1:0];
                CFG_TILE_IN_HEIGHT:  cfg_next.tile_in_height  = cfg_data[CFG_DIM_W-1:0];
                CFG_TILE_IN_WIDTH:   cfg_next.tile_in_width   = cfg_data[CFG_DIM_W-1:0];
                CFG_FRAME_SIDE:      cfg_next.frame_side      = cfg_data[CFG_FRAME_W-1:0];
                default:             cfg_next = cfg_reg;   // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_channels   <= CFG_CH_W'(8);
            cfg_reg.tile_out_height <= CFG_DIM_W'(1);
            cfg_reg.tile_out_width  <= CFG_DIM_W'(1);
            cfg_reg.tile_in_height  <= CFG_DIM_W'(1);
            cfg_reg.tile_in_width   <= CFG_DIM_W'(1);
            cfg_reg.frame_side      <= CFG_FRAME_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/tfag_ctrl.sv */
// ----------------------------------------------------------------------------
// tfag_ctrl
// Sequencer: takes requests, walks the multiplier schedule for a step and
// commits the result once the output register is free.
// ----------------------------------------------------------------------------
module tfag_ctrl
    import tfag_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    req_kind,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.start_load = 1'b0;
        cmd.uop        = UOP_NONE;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start_load = (req_kind == REQ_START);
                    if ((req_kind == REQ_STEP) && status.active)
                    begin
                        state_next = ST_FF;
                    end
                end
            end
            ST_FF:
            begin
                cmd.uop    = UOP_FF;
                state_next = ST_CH;
            end
            ST_CH:
            begin
                cmd.uop    = UOP_CH;
                state_next = ST_Y;
            end
            ST_Y:
            begin
                cmd.uop    = UOP_Y;
                state_next = ST_CF;
            end
            ST_CF:
            begin
                cmd.uop    = UOP_CF;
                state_next = ST_YF;
            end
            ST_YF:
            begin
                cmd.uop    = UOP_YF;
                state_next = ST_X;
            end
            ST_X:
            begin
                cmd.uop    = UOP_X;
                state_next = ST_GI;
            end
            ST_GI:
            begin
                cmd.uop    = UOP_GI;
                state_next = ST_RH;
            end
            ST_RH:
            begin
                cmd.uop    = UOP_RH;
                state_next = ST_RS;
            end
            ST_RS:
            begin
                cmd.uop    = UOP_RS;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.uop = UOP_FIN;
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // schedule is entered only from idle
    a_ff_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FF) |-> $past(state_reg == ST_IDLE))
        else $error("step schedule entered from a busy state");

    // a stalled result keeps the sequencer parked in FIN
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && status.out_busy) |=> (state_reg == ST_FIN))
        else $error("left FIN while the output register was occupied");

    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == ST_IDLE && req_ready))
        else $error("not ready for a new request after commit");

endmodule

/* hdl/tfag_datapath.sv */
// ----------------------------------------------------------------------------
// tfag_datapath
// Tile state, loop counters, shared 32-bit multiplier with accumulators, and
// the output register.
// ----------------------------------------------------------------------------
module tfag_datapath
    import tfag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [TILE_IDX_W-1:0] channel_tile,
    input  logic [TILE_IDX_W-1:0] row_tile,
    input  logic [TILE_IDX_W-1:0] col_tile,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     out_source_address,
    output logic [ROW_W-1:0]      out_buffer_row,
    output logic [PORT_W-1:0]     out_buffer_port,
    output logic                  out_row_overflow,
    output logic                  out_last
);

    // tile state
    logic                  active_reg, active_next;
    logic [GRP_CNT_W-1:0]  group_count_reg, group_count_next;
    logic [DIM_CNT_W-1:0]  row_count_reg, row_count_next;
    logic [DIM_CNT_W-1:0]  col_count_reg, col_count_next;
    logic [TILE_IDX_W-1:0] held_ct_reg, held_ct_next;
    logic [TILE_IDX_W-1:0] held_rt_reg, held_rt_next;
    logic [TILE_IDX_W-1:0] held_cl_reg, held_cl_next;

    // arithmetic registers
    logic [MUL_W-1:0]     prod_reg, prod_next;
    logic [MUL_W-1:0]     ff_reg, ff_next;
    logic [MUL_W-1:0]     chan_reg, chan_next;
    logic [MUL_W-1:0]     y_reg, y_next;
    logic [MUL_W-1:0]     acc_reg, acc_next;
    logic [ROW_ACC_W-1:0] row_acc_reg, row_acc_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [PORT_W-1:0]    out_port_reg;
    logic                 out_ovf_reg;
    logic                 out_last_reg;

    // derived bounds from live configuration
    logic [CFG_CH_W-1:0]  grp_div;
    logic [GRP_W-1:0]     groups;
    logic [CFG_DIM_W-1:0] ih_sat;
    logic [CFG_DIM_W-1:0] iw_sat;
    logic [STRIDE_W-1:0]  stride;
    logic                 col_end, row_end, grp_end, last_step;

    logic [MUL_W-1:0]     mul_a, mul_b, mul_lo;
    logic                 prod_load;
    logic [ROW_ACC_W-1:0] row_full;
    logic [DIM_CNT_W-1:0] col_quot;

    assign grp_div = CFG_CH_W'(cfg.tile_channels / VECTOR_WIDTH);
    assign groups  = (GRP_W'(grp_div) > GROUPS_MAX) ? GROUPS_MAX : GRP_W'(grp_div);
    assign ih_sat  = (cfg.tile_in_height > DIM_MAX) ? DIM_MAX : cfg.tile_in_height;
    assign iw_sat  = (cfg.tile_in_width > DIM_MAX) ? DIM_MAX : cfg.tile_in_width;
    assign stride  = STRIDE_W'(iw_sat / PORT_COUNT) + STRIDE_W'(1);

    assign col_end   = (CFG_DIM_W'(col_count_reg) + CFG_DIM_W'(1)) >= iw_sat;
    assign row_end   = (CFG_DIM_W'(row_count_reg) + CFG_DIM_W'(1)) >= ih_sat;
    assign grp_end   = (GRP_W'(group_count_reg) + GRP_W'(1)) >= groups;
    assign last_step = col_end && row_end && grp_end;

    assign col_quot = DIM_CNT_W'(col_count_reg / PORT_COUNT);
    assign row_full = row_acc_reg + prod_reg[ROW_ACC_W-1:0];

    // low word only: every address term is taken modulo 2^32
    assign mul_lo = mul_a * mul_b;

    // multiplier schedule: each product lands in prod_reg and is folded in
    // on the following micro-op
    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        prod_load    = 1'b0;
        ff_next      = ff_reg;
        chan_next    = chan_reg;
        y_next       = y_reg;
        acc_next     = acc_reg;
        row_acc_next = row_acc_reg;
        unique case (cmd.uop)
            UOP_FF:
            begin
                mul_a     = MUL_W'(cfg.frame_side);
                mul_b     = MUL_W'(cfg.frame_side);
                prod_load = 1'b1;
            end
            UOP_CH:
            begin
                mul_a     = MUL_W'(held_ct_reg);
                mul_b     = MUL_W'(groups);
                prod_load = 1'b1;
                ff_next   = prod_reg;
            end
            UOP_Y:
            begin
                mul_a     = MUL_W'(held_rt_reg);
                mul_b     = MUL_W'(cfg.tile_out_height);
                prod_load = 1'b1;
                chan_next = prod_reg + MUL_W'(group_count_reg);
            end
            UOP_CF:
            begin
                mul_a     = chan_reg;
                mul_b     = ff_reg;
                prod_load = 1'b1;
                y_next    = prod_reg + MUL_W'(row_count_reg);
            end
            UOP_YF:
            begin
                mul_a     = y_reg;
                mul_b     = MUL_W'(cfg.frame_side);
                prod_load = 1'b1;
                acc_next  = prod_reg;
            end
            UOP_X:
            begin
                mul_a     = MUL_W'(held_cl_reg);
                mul_b     = MUL_W'(cfg.tile_out_width);
                prod_load = 1'b1;
                acc_next  = acc_reg + prod_reg;
            end
            UOP_GI:
            begin
                mul_a     = MUL_W'(group_count_reg);
                mul_b     = MUL_W'(ih_sat);
                prod_load = 1'b1;
                acc_next  = acc_reg + prod_reg;
            end
            UOP_RH:
            begin
                mul_a     = prod_reg;
                mul_b     = MUL_W'(stride);
                prod_load = 1'b1;
                acc_next  = acc_reg + MUL_W'(col_count_reg);
            end
            UOP_RS:
            begin
                mul_a        = MUL_W'(row_count_reg);
                mul_b        = MUL_W'(stride);
                prod_load    = 1'b1;
                row_acc_next = prod_reg[ROW_ACC_W-1:0] + ROW_ACC_W'(col_quot);
            end
            UOP_NONE, UOP_FIN:
            begin
                prod_load = 1'b0;
            end
            default:
            begin
                prod_load = 1'b0;
            end
        endcase
    end

    assign prod_next = prod_load ? mul_lo : prod_reg;

    // tile state and counters
    always_comb
    begin
        active_next      = active_reg;
        group_count_next = group_count_reg;
        row_count_next   = row_count_reg;
        col_count_next   = col_count_reg;
        held_ct_next     = held_ct_reg;
        held_rt_next     = held_rt_reg;
        held_cl_next     = held_cl_reg;
        if (cmd.start_load)
        begin
            held_ct_next     = channel_tile;
            held_rt_next     = row_tile;
            held_cl_next     = col_tile;
            group_count_next = '0;
            row_count_next   = '0;
            col_count_next   = '0;
            active_next      = (groups != '0) && (ih_sat != '0) && (iw_sat != '0);
        end
        else if (cmd.commit)
        begin
            priority if (last_step)
            begin
                active_next      = 1'b0;
                group_count_next = '0;
                row_count_next   = '0;
                col_count_next   = '0;
            end
            else if (!col_end)
            begin
                col_count_next = col_count_reg + DIM_CNT_W'(1);
            end
            else if (!row_end)
            begin
                col_count_next = '0;
                row_count_next = row_count_reg + DIM_CNT_W'(1);
            end
            else
            begin
                col_count_next   = '0;
                row_count_next   = '0;
                group_count_next = group_count_reg + GRP_CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            group_count_reg <= '0;
            row_count_reg   <= '0;
            col_count_reg   <= '0;
            held_ct_reg     <= '0;
            held_rt_reg     <= '0;
            held_cl_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            group_count_reg <= group_count_next;
            row_count_reg   <= row_count_next;
            col_count_reg   <= col_count_next;
            held_ct_reg     <= held_ct_next;
            held_rt_reg     <= held_rt_next;
            held_cl_reg     <= held_cl_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        ff_reg      <= ff_next;
        chan_reg    <= chan_next;
        y_reg       <= y_next;
        acc_reg     <= acc_next;
        row_acc_reg <= row_acc_next;
        if (cmd.commit)
        begin
            out_addr_reg <= ADDR_W'(acc_reg * VECTOR_WIDTH);
            out_row_reg  <= row_full[ROW_W-1:0];
            out_port_reg <= PORT_W'(col_count_reg % PORT_COUNT);
            out_ovf_reg  <= (row_full >= ROW_ACC_W'(BUFFER_ROWS));
            out_last_reg <= last_step;
        end
    end

    assign status.active   = active_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid          = out_valid_reg;
    assign out_source_address = out_addr_reg;
    assign out_buffer_row     = out_row_reg;
    assign out_buffer_port    = out_port_reg;
    assign out_row_overflow   = out_ovf_reg;
    assign out_last           = out_last_reg;

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result committed over a stalled output");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    // counters rest at zero whenever no tile runs
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (group_count_reg == '0 && row_count_reg == '0
                         && col_count_reg == '0))
        else $error("loop counters not cleared outside a tile");

endmodule

/* hdl/tile_fetch_addr_gen_channel_major.sv */
// ----------------------------------------------------------------------------
// tile_fetch_addr_gen_channel_major
// Address generator for fetching one input-feature tile into the on-chip
// buffer, channel groups outermost, columns innermost.
// ----------------------------------------------------------------------------
// Use:
//   Requests arrive on the s_axis group. tuser = 0 is a start request: it
//   latches the channel/row/column tile indices from tdata, clears the loop
//   counters and arms the tile unless the live bounds make it empty. tuser = 1
//   is a step request: while a tile is armed it yields one transfer on the
//   m_axis group (source element address, buffer row and port in tdata,
//   row-overflow flag in tuser, tlast on the final transfer of the tile).
//   A step with no tile armed is swallowed without a result.
// Timing:
//   Start and idle step requests leave the sequencer idle. A live step's
//   result is registered on commit, and the next request is taken once the
//   sequencer is back in idle: one shared 32x32 multiplier works through
//   nine products in turn, since the live registers are used on every step.
//   The result may still be waiting downstream.
// Reset:
//   Registers return to 8, 1, 1, 1, 1, 1; no tile armed, output empty.
// Stall:
//   If m_axis_tready stays low, a finished second result waits in the
//   sequencer and no further request is taken until the first is gone.
// Configuration is written through cfg_we / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module tile_fetch_addr_gen_channel_major
    import tfag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] channel_tile, [23:12] row_tile, [35:24] col_tile, [39:36] zero
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                  s_axis_tuser,

    // transfers
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] source_address, [43:32] buffer_row, [45:44] buffer_port,
    // [47:46] zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [0] row_overflow
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int M_PAD_W = M_TDATA_W - ADDR_W - ROW_W - PORT_W;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    logic [ADDR_W-1:0] source_address;
    logic [ROW_W-1:0]  buffer_row;
    logic [PORT_W-1:0] buffer_port;

    tfag_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: request handshake and step schedule
    tfag_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_kind  (s_axis_tuser),
        .req_ready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // tile state, multiplier and output register
    tfag_datapath u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .status             (status),
        .channel_tile       (s_axis_tdata[TILE_IDX_W-1:0]),
        .row_tile           (s_axis_tdata[2*TILE_IDX_W-1:TILE_IDX_W]),
        .col_tile           (s_axis_tdata[3*TILE_IDX_W-1:2*TILE_IDX_W]),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .out_source_address (source_address),
        .out_buffer_row     (buffer_row),
        .out_buffer_port    (buffer_port),
        .out_row_overflow   (m_axis_tuser),
        .out_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, buffer_port, buffer_row, source_address};

endmodule
